### rtl/iambic_morse_keyer_macros.svh
// ---------------------------------------------------------------------------
// Iambic keyer assertion macros
// Concurrent assertion wrappers shared by the keyer RTL files.
// ---------------------------------------------------------------------------
`ifndef IAMBIC_MORSE_KEYER_MACROS_SVH
`define IAMBIC_MORSE_KEYER_MACROS_SVH

`ifndef ASSERT_OFF
// check a property on every clock edge outside reset
`define IMK_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// check that a condition implies another condition in the next cycle
`define IMK_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define IMK_ASSERT(lbl, clk, rstn, prop, msg)
`define IMK_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

### rtl/imk_pkg.sv
// ---------------------------------------------------------------------------
// Iambic keyer package
// Shared types, codes and timing limits for the keyer.
// ---------------------------------------------------------------------------
`default_nettype none

package imk_pkg;

  // key modes, written through configuration register 0
  typedef enum logic [1:0] {
    MODE_STRAIGHT = 2'd0,
    MODE_IAMBIC_A = 2'd1,
    MODE_IAMBIC_B = 2'd2,
    MODE_PASS     = 2'd3
  } imk_mode_t;

  // configuration register indexes
  localparam logic CFG_KEY_MODE    = 1'b0;
  localparam logic CFG_SPEED_INDEX = 1'b1;

  // element state, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIT  = 3'b010,
    ST_DAH  = 3'b100
  } imk_elem_t;

  // line levels: bit0 dit, bit1 dah, bit2 tone
  localparam logic [2:0] LVL_OFF    = 3'b000;
  localparam logic [2:0] LVL_DIT_ON = 3'b101;
  localparam logic [2:0] LVL_DAH_ON = 3'b110;

  // dit lengths in ms
  localparam logic [8:0] DIT_SLOW   = 9'd120;
  localparam logic [8:0] DIT_MEDIUM = 9'd80;
  localparam logic [8:0] DIT_FAST   = 9'd60;
  localparam logic [8:0] DIT_TURBO  = 9'd40;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        left_pressed;
    logic        right_pressed;
    logic        paddle_dit_closed;
    logic        paddle_dah_closed;
  } imk_sample_t;

  typedef struct packed {
    imk_elem_t   elem;
    logic        done;
    logic        extra;
    logic [31:0] start;
    logic [2:0]  levels;
  } imk_state_t;

  // time limit of a number of dit units at the given speed
  function automatic logic [8:0] imk_limit(input logic [1:0] spd, input logic [2:0] units);
    logic [8:0]  unit_len;
    logic [11:0] prod;
    case (spd)
      2'd0:    unit_len = DIT_SLOW;
      2'd1:    unit_len = DIT_MEDIUM;
      2'd2:    unit_len = DIT_FAST;
      default: unit_len = DIT_TURBO;
    endcase
    prod = 12'(unit_len) * 12'(units);
    return prod[8:0];
  endfunction

endpackage

`default_nettype wire

### rtl/imk_ifs.sv
// ---------------------------------------------------------------------------
// Iambic keyer channel interfaces
// Valid/ready channels for key samples and line levels.
// ---------------------------------------------------------------------------
`default_nettype none

interface imk_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        left_pressed;
  logic        right_pressed;
  logic        paddle_dit_closed;
  logic        paddle_dah_closed;

  modport source (
    output valid, now_ms, left_pressed, right_pressed,
           paddle_dit_closed, paddle_dah_closed,
    input  ready
  );
  modport sink (
    input  valid, now_ms, left_pressed, right_pressed,
           paddle_dit_closed, paddle_dah_closed,
    output ready
  );
endinterface

interface imk_out_if;
  logic valid;
  logic ready;
  logic dit_line;
  logic dah_line;
  logic tone_on;

  modport source (output valid, dit_line, dah_line, tone_on, input ready);
  modport sink   (input  valid, dit_line, dah_line, tone_on, output ready);
endinterface

`default_nettype wire

### rtl/imk_step.sv
// ---------------------------------------------------------------------------
// Iambic keyer step logic
// Next keyer state and line levels for one registered sample.
// ---------------------------------------------------------------------------
`default_nettype none

module imk_step (
  input  imk_pkg::imk_mode_t   key_mode,
  input  logic [1:0]           speed_index,
  input  imk_pkg::imk_sample_t sample,
  input  imk_pkg::imk_state_t  cur,
  output imk_pkg::imk_state_t  nxt
);
  import imk_pkg::*;

  logic        want_dit;
  logic        want_dah;
  logic        any_req;
  imk_elem_t   opp_elem;
  imk_state_t  upd;
  logic [31:0] elapsed;
  logic [8:0]  on_lim;
  logic [8:0]  off_lim;

  assign want_dit = sample.left_pressed  | sample.paddle_dit_closed;
  assign want_dah = sample.right_pressed | sample.paddle_dah_closed;
  assign any_req  = want_dit | want_dah;
  assign opp_elem = (cur.elem == ST_DIT) ? ST_DAH : ST_DIT;

  // element transitions
  always_comb begin
    upd = cur;
    if (any_req && cur.elem == ST_IDLE) begin
      upd.elem  = want_dit ? ST_DIT : ST_DAH;
      upd.start = sample.now_ms;
    end else if (want_dit && want_dah) begin
      if (cur.done) begin
        upd.extra = cur.extra | (key_mode == MODE_IAMBIC_B);
        upd.elem  = opp_elem;
        upd.start = sample.now_ms;
        upd.done  = 1'b0;
      end
    end else if (!any_req && cur.elem != ST_IDLE && cur.done) begin
      if (cur.extra) begin
        upd.extra = 1'b0;
        upd.elem  = opp_elem;
        upd.start = sample.now_ms;
        upd.done  = 1'b0;
      end else begin
        upd.elem   = ST_IDLE;
        upd.done   = 1'b0;
        upd.start  = '0;
        upd.levels = LVL_OFF;
      end
    end
  end

  assign elapsed = sample.now_ms - upd.start;
  assign on_lim  = imk_limit(speed_index, (upd.elem == ST_DAH) ? 3'd3 : 3'd1);
  assign off_lim = imk_limit(speed_index, (upd.elem == ST_DAH) ? 3'd4 : 3'd2);

  always_comb begin
    nxt = cur;
    case (key_mode)
      MODE_STRAIGHT: nxt.levels = any_req ? LVL_DIT_ON : LVL_OFF;
      MODE_PASS:     nxt.levels = {1'b0, sample.paddle_dah_closed, sample.paddle_dit_closed};
      default: begin
        nxt = upd;
        if (upd.elem != ST_IDLE) begin
          if (elapsed < {23'd0, on_lim}) begin
            nxt.levels = (upd.elem == ST_DAH) ? LVL_DAH_ON : LVL_DIT_ON;
            nxt.done   = 1'b0;
          end else if (elapsed < {23'd0, off_lim}) begin
            nxt.levels = LVL_OFF;
            nxt.done   = 1'b0;
          end else begin
            // element over: restart the clock for a repeat
            nxt.start  = sample.now_ms;
            nxt.levels = LVL_OFF;
            nxt.done   = 1'b1;
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/iambic_morse_keyer.sv
// ---------------------------------------------------------------------------
// Iambic Morse keyer
// Straight, passthrough and iambic A/B keying of timestamped key samples.
// ---------------------------------------------------------------------------
// Each transaction on in_ch is one sample of the two touch buttons and the
// two paddle contacts with its millisecond timestamp; each produces exactly
// one transaction on out_ch with the dit line, dah line and sidetone levels.
// A sample is captured in an input register, runs through the step logic
// (which also updates the element state, flags, element start time and
// held line levels) and moves into the result register when that register is
// empty or being drained; one sample is taken every clock while out_ch
// keeps up. The result register parts the two sides: a new sample is taken
// while a finished result still waits, as long as the input register is
// empty. Element timing compares the wrapped 32-bit elapsed time against
// 1, 2, 3 or 4 dit lengths of 120, 80, 60 or 40 ms. Write key_mode (index 0)
// and speed_index (index 1) through the cfg port only while no transaction
// is in flight; the iambic state is kept across mode changes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "iambic_morse_keyer_macros.svh"

module iambic_morse_keyer (
  input  logic       clk,
  input  logic       rst_n,
  imk_in_if.sink     in_ch,
  imk_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_wdata
);
  import imk_pkg::*;

  // configuration
  imk_mode_t   key_mode_r;
  logic [1:0]  speed_index_r;

  // input stage
  logic        s1_v_r, s1_v_nxt;
  imk_sample_t s1_smp_r;

  // keyer state
  imk_state_t  state_r;
  imk_state_t  state_nxt;

  // result stage
  logic        out_v_r, out_v_nxt;
  logic [2:0]  out_lvl_r;

  logic        in_fire;
  logic        adv;

  // advance the result register whenever it is empty or being drained
  assign adv          = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  assign out_v_nxt = adv ? s1_v_r : out_v_r;

  imk_step u_step (
    .key_mode    (key_mode_r),
    .speed_index (speed_index_r),
    .sample      (s1_smp_r),
    .cur         (state_r),
    .nxt         (state_nxt)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r    <= MODE_STRAIGHT;
      speed_index_r <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_MODE:    key_mode_r    <= imk_mode_t'(cfg_wdata);
        CFG_SPEED_INDEX: speed_index_r <= cfg_wdata;
        default:         key_mode_r    <= key_mode_r;
      endcase
    end
  end

  // control and keyer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '{elem: ST_IDLE, done: 1'b0, extra: 1'b0, start: 32'd0, levels: LVL_OFF};
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      // commit the step only when its result moves into the result register
      if (adv && s1_v_r) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_smp_r <= '{now_ms:            in_ch.now_ms,
                    left_pressed:      in_ch.left_pressed,
                    right_pressed:     in_ch.right_pressed,
                    paddle_dit_closed: in_ch.paddle_dit_closed,
                    paddle_dah_closed: in_ch.paddle_dah_closed};
    end
    if (adv && s1_v_r) begin
      out_lvl_r <= state_nxt.levels;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.dit_line = out_lvl_r[0];
  assign out_ch.dah_line = out_lvl_r[1];
  assign out_ch.tone_on  = out_lvl_r[2];

  // idle always carries a clear done flag and a zero start time
  `IMK_ASSERT(a_idle_clean, clk, rst_n, (state_r.elem != ST_IDLE) || (!state_r.done && state_r.start == 32'd0), "idle state with stale done flag or start time")
  // a pending extra element only exists while an element runs
  `IMK_ASSERT(a_extra_busy, clk, rst_n, !state_r.extra || (state_r.elem != ST_IDLE), "extra element pending while idle")
  // a sample that advances always yields a result
  `IMK_ASSERT_NEXT(a_adv_result, clk, rst_n, adv && s1_v_r, out_v_r, "advanced sample produced no result")
  // an empty result register never blocks the input
  `IMK_ASSERT(a_no_false_stall, clk, rst_n, out_v_r || in_ch.ready, "input stalled with empty result register")

endmodule

`default_nettype wire
